### src/segment_plane_intersect_defines.svh
// Assertion macros for the checker file of the segment/plane block.
`ifndef SEGMENT_PLANE_INTERSECT_DEFINES_SVH
`define SEGMENT_PLANE_INTERSECT_DEFINES_SVH

// Checked only while the block is out of reset.
`define SPI_ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment_plane_intersect: run-time check failed");

// Checked at every edge, including during reset.
`define SPI_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("segment_plane_intersect: reset check failed");

`endif

### src/spi_pkg.sv
// Shared widths, codes and payload types of the segment/plane block.
package spi_pkg;

  localparam int CW    = 32;            // coordinate width
  localparam int FRAC  = 16;            // coordinate fraction bits
  localparam int THW   = 32;            // parallel threshold width
  localparam int IW    = 3;             // register index width
  localparam int UW    = CW + 1;        // segment direction width
  localparam int PW    = CW + UW;       // one normal-times-direction product
  localparam int DW    = PW + 2;        // sum of three products
  localparam int AW    = DW;            // magnitude of D or N
  localparam int RW    = AW + 2;        // signed divider candidate
  localparam int QDEP  = 4;             // queue depth
  localparam int QPW   = $clog2(QDEP);

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_DISJ  = 2'd1;
  localparam logic [1:0] KIND_PLANE = 2'd2;

  localparam logic [IW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [IW-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [IW-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [IW-1:0] REG_NORMAL_Z = 3'd5;
  localparam logic [IW-1:0] REG_THRESH   = 3'd6;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0] st;
    coord_t [2:0] en;
  } seg_t;

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] nrm;
    logic [THW-1:0] thr;
  } plane_t;

  // One classified segment, as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    coord_t [2:0] p1;
    logic [2:0] usgn;
    logic [2:0][UW-1:0] umag;
    logic [AW-1:0] ad;
    logic [AW-1:0] an;
  } job_t;

  // One step of the hit-point divider, three lanes wide.
  typedef struct packed {
    logic [1:0] kind;
    coord_t [2:0] p1;
    logic [2:0] usgn;
    logic [2:0][UW-1:0] umag;
    logic [RW-1:0] an;
    logic [RW-1:0] e1;
    logic [RW-1:0] e2;
    logic [RW-1:0] nad;
    logic [2:0][AW-1:0] r;
    logic [2:0][UW-1:0] q;
  } bst_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t [2:0] hit;
  } res_t;

endpackage

### src/spi_seg_if.sv
// Segment input channel.
interface spi_seg_if import spi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

### src/spi_res_if.sv
// Result output channel.
interface spi_res_if import spi_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  coord_t     hit_x;
  coord_t     hit_y;
  coord_t     hit_z;

  modport source (output valid, kind, hit_x, hit_y, hit_z, input ready);
  modport sink (input valid, kind, hit_x, hit_y, hit_z, output ready);
endinterface

### src/spi_cfg_if.sv
// Configuration register write channel.
interface spi_cfg_if import spi_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [CW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/segment_plane_intersect.sv
// Segment against plane intersection test, top level.
//
// Segments enter on in_seg (start and end points, signed Q16.16) and one
// result per segment leaves on out_res: a kind code (unique hit, disjoint,
// or in plane) and the hit point, which is zero unless the kind is a hit.
// The plane origin, normal and parallel threshold are written through
// cfg_wr, register i at index i; writes are always taken (ready stays high)
// and must only be made while no segment is in flight.
// A transfer happens on a rising edge with valid and ready both high.
// Throughput is one segment per cycle while nothing stalls. The input
// transfer loads the first of 40 register stages: four front stages for
// the dot products and classification, one queue slot, and a back
// pipeline of 35 stages (setup, 33 quotient digits, rounding).
// When the receiver stalls, the back pipeline and the result hold; the
// front keeps going until its four-entry queue fills, then in_seg.ready
// drops. Synchronous active-low reset empties the pipelines and the queue
// and loads origin (0,0,0), normal (0,0,1.0) and a zero threshold.
module segment_plane_intersect import spi_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  spi_seg_if.sink  in_seg,
  spi_res_if.source out_res,
  spi_cfg_if.sink  cfg_wr
);

  plane_t plane_r;
  seg_t   seg;
  job_t   fjob, qjob;
  logic   push, pop, q_full, q_empty;
  res_t   res;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.org <= '0;
      plane_r.nrm <= {coord_t'(1) << FRAC, coord_t'(0), coord_t'(0)};
      plane_r.thr <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_ORIGIN_X: plane_r.org[0] <= cfg_wr.data;
        REG_ORIGIN_Y: plane_r.org[1] <= cfg_wr.data;
        REG_ORIGIN_Z: plane_r.org[2] <= cfg_wr.data;
        REG_NORMAL_X: plane_r.nrm[0] <= cfg_wr.data;
        REG_NORMAL_Y: plane_r.nrm[1] <= cfg_wr.data;
        REG_NORMAL_Z: plane_r.nrm[2] <= cfg_wr.data;
        REG_THRESH:   plane_r.thr    <= cfg_wr.data[THW-1:0];
        default: ;
      endcase
    end
  end

  assign seg.st = {in_seg.start_z, in_seg.start_y, in_seg.start_x};
  assign seg.en = {in_seg.end_z, in_seg.end_y, in_seg.end_x};

  spi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_seg.valid),
    .in_ready (in_seg.ready),
    .seg      (seg),
    .plane    (plane_r),
    .q_full   (q_full),
    .push     (push),
    .job      (fjob)
  );

  spi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fjob),
    .pop   (pop),
    .rdata (qjob),
    .full  (q_full),
    .empty (q_empty)
  );

  spi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (qjob),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .res       (res)
  );

  assign out_res.kind  = res.kind;
  assign out_res.hit_x = res.hit[0];
  assign out_res.hit_y = res.hit[1];
  assign out_res.hit_z = res.hit[2];

endmodule

### src/spi_front.sv
// Front pipeline: forms D and N and classifies each segment.
module spi_front import spi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  seg_t   seg,
  input  plane_t plane,
  input  logic   q_full,
  output logic   push,
  output job_t   job
);

  logic fe;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  coord_t [2:0]         s1_p1_r, s2_p1_r, s3_p1_r;
  logic [2:0][UW-1:0]   s1_u_r, s2_u_r, s3_u_r;
  logic [2:0][UW-1:0]   s1_w_r;
  logic [2:0][PW-1:0]   s2_pu_r, s2_pw_r;
  logic [DW-1:0]        s3_d_r, s3_n_r;
  job_t                 job_r;

  logic [2:0][UW-1:0]   u_nxt, w_nxt;
  logic [2:0][PW-1:0]   pu_nxt, pw_nxt;
  logic [DW-1:0]        d_nxt, n_nxt, wsum;
  job_t                 job_nxt;
  logic [AW-1:0]        ad, an;
  logic                 par;

  function automatic logic [DW-1:0] sxp(input logic [PW-1:0] p);
    sxp = {{(DW-PW){p[PW-1]}}, p};
  endfunction

  assign fe       = !s4_v_r || !q_full;
  assign in_ready = fe;
  assign push     = s4_v_r && !q_full;
  assign job      = job_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i]  = {seg.en[i][CW-1], seg.en[i]} - {seg.st[i][CW-1], seg.st[i]};
      w_nxt[i]  = {seg.st[i][CW-1], seg.st[i]} - {plane.org[i][CW-1], plane.org[i]};
      pu_nxt[i] = $signed(plane.nrm[i]) * $signed(s1_u_r[i]);
      pw_nxt[i] = $signed(plane.nrm[i]) * $signed(s1_w_r[i]);
    end
    d_nxt = sxp(s2_pu_r[0]) + sxp(s2_pu_r[1]) + sxp(s2_pu_r[2]);
    wsum  = sxp(s2_pw_r[0]) + sxp(s2_pw_r[1]) + sxp(s2_pw_r[2]);
    n_nxt = -wsum;
  end

  // Classification: parallel test, then the range test on s = N/D.
  always_comb begin
    ad  = s3_d_r[DW-1] ? -s3_d_r : s3_d_r;
    an  = s3_n_r[DW-1] ? -s3_n_r : s3_n_r;
    par = ad <= {{(AW-THW){1'b0}}, plane.thr};
    job_nxt.p1 = s3_p1_r;
    job_nxt.ad = ad;
    job_nxt.an = an;
    for (int i = 0; i < 3; i++) begin
      job_nxt.usgn[i] = s3_u_r[i][UW-1];
      job_nxt.umag[i] = s3_u_r[i][UW-1] ? -s3_u_r[i] : s3_u_r[i];
    end
    if (par) begin
      job_nxt.kind = (s3_n_r == '0) ? KIND_PLANE : KIND_DISJ;
    end else if (s3_n_r != '0 && (s3_n_r[DW-1] != s3_d_r[DW-1] || an > ad)) begin
      job_nxt.kind = KIND_DISJ;
    end else begin
      job_nxt.kind = KIND_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (fe) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      s1_p1_r <= seg.st;
      s1_u_r  <= u_nxt;
      s1_w_r  <= w_nxt;
      s2_p1_r <= s1_p1_r;
      s2_u_r  <= s1_u_r;
      s2_pu_r <= pu_nxt;
      s2_pw_r <= pw_nxt;
      s3_p1_r <= s2_p1_r;
      s3_u_r  <= s2_u_r;
      s3_d_r  <= d_nxt;
      s3_n_r  <= n_nxt;
      job_r   <= job_nxt;
    end
  end

endmodule

### src/spi_queue.sv
// Short queue between the classifying front and the divider back.
module spi_queue import spi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic full,
  output logic empty
);

  job_t           mem_r [QDEP];
  logic [QPW:0]   wp_r, rp_r;

  assign empty = wp_r == rp_r;
  assign full  = (wp_r[QPW] != rp_r[QPW]) && (wp_r[QPW-1:0] == rp_r[QPW-1:0]);
  assign rdata = mem_r[rp_r[QPW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r[QPW-1:0]] <= wdata;
  end

endmodule

### src/spi_back.sv
// Back pipeline: one quotient digit per stage for each axis, then rounding.
module spi_back import spi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t job,
  input  logic q_empty,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  logic          be;
  logic [UW:0]   v_r;
  bst_t          st_r [UW+1];
  bst_t          st0_nxt;
  logic          fin_v_r;
  res_t          res_r, res_nxt;

  assign be        = !fin_v_r || out_ready;
  assign pop       = !q_empty && be;
  assign out_valid = fin_v_r;
  assign res       = res_r;

  always_comb begin
    st0_nxt.kind = job.kind;
    st0_nxt.p1   = job.p1;
    st0_nxt.usgn = job.usgn;
    st0_nxt.umag = job.umag;
    st0_nxt.an   = {2'b00, job.an};
    st0_nxt.e1   = {2'b00, job.an} - {2'b00, job.ad};
    st0_nxt.e2   = {2'b00, job.an} - {1'b0, job.ad, 1'b0};
    st0_nxt.nad  = -{2'b00, job.ad};
    st0_nxt.r    = '0;
    st0_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (be) st_r[0] <= st0_nxt;
  end

  // Each stage keeps AN*prefix(|u|) = q*AD + r with r < AD; the remainder
  // can reach 3*AD before reduction, so up to two AD are taken off.
  for (genvar s = 1; s <= UW; s++) begin : g_step
    bst_t nxt;
    always_comb begin
      logic [RW-1:0] tr, c0, c1, c2;
      logic          b;
      nxt = st_r[s-1];
      for (int l = 0; l < 3; l++) begin
        b  = st_r[s-1].umag[l][UW-s];
        tr = {1'b0, st_r[s-1].r[l], 1'b0};
        c0 = tr + (b ? st_r[s-1].an : '0);
        c1 = tr + (b ? st_r[s-1].e1 : st_r[s-1].nad);
        c2 = tr + (b ? st_r[s-1].e2 : {st_r[s-1].nad[RW-2:0], 1'b0});
        if (!c2[RW-1]) begin
          nxt.r[l] = c2[AW-1:0];
          nxt.q[l] = {st_r[s-1].q[l][UW-2:0], 1'b0} + UW'(2);
        end else if (!c1[RW-1]) begin
          nxt.r[l] = c1[AW-1:0];
          nxt.q[l] = {st_r[s-1].q[l][UW-2:0], 1'b1};
        end else begin
          nxt.r[l] = c0[AW-1:0];
          nxt.q[l] = {st_r[s-1].q[l][UW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (be) st_r[s] <= nxt;
    end
  end

  // Round half away from the start point: bump q when 2r >= AD.
  always_comb begin
    logic [RW-1:0] rc;
    logic [UW:0]   qf;
    logic [CW+1:0] hv;
    res_nxt.kind = st_r[UW].kind;
    for (int l = 0; l < 3; l++) begin
      rc = {1'b0, st_r[UW].r[l], 1'b0} + st_r[UW].nad;
      qf = {1'b0, st_r[UW].q[l]} + {{UW{1'b0}}, !rc[RW-1]};
      if (st_r[UW].usgn[l]) begin
        hv = {{2{st_r[UW].p1[l][CW-1]}}, st_r[UW].p1[l]} - qf;
      end else begin
        hv = {{2{st_r[UW].p1[l][CW-1]}}, st_r[UW].p1[l]} + qf;
      end
      res_nxt.hit[l] = (st_r[UW].kind == KIND_HIT) ? hv[CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      fin_v_r <= 1'b0;
    end else if (be) begin
      v_r     <= {v_r[UW-1:0], pop};
      fin_v_r <= v_r[UW];
    end
  end

  always_ff @(posedge clk) begin
    if (be) res_r <= res_nxt;
  end

endmodule

### src/spi_checker.sv
// Port-level checks of the segment/plane block and their binding.
`include "segment_plane_intersect_defines.svh"

module spi_checker import spi_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input coord_t     out_hit_x,
  input coord_t     out_hit_y,
  input coord_t     out_hit_z
);

  `SPI_ASSERT_ANY(a_no_result_after_reset, $past(!rst_n) |-> !out_valid)
  `SPI_ASSERT_RUN(a_miss_has_zero_hit, out_valid && out_kind != KIND_HIT |-> out_hit_x == 0 && out_hit_y == 0 && out_hit_z == 0)
  `SPI_ASSERT_RUN(a_stall_keeps_valid, out_valid && !out_ready |=> out_valid)
  `SPI_ASSERT_RUN(a_stall_keeps_result, out_valid && !out_ready |=> $stable(out_kind) && $stable(out_hit_x) && $stable(out_hit_y) && $stable(out_hit_z))

endmodule

bind segment_plane_intersect spi_checker u_spi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_kind  (out_res.kind),
  .out_hit_x (out_res.hit_x),
  .out_hit_y (out_res.hit_y),
  .out_hit_z (out_res.hit_z)
);
